[design/dsef_pkg.sv]
// Shared types and constants for the DLE/STX/ETX packet framer.
// No dependencies; every other file of the framer imports this package.
`default_nettype none

package dsef_pkg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       burst_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] escape_char;
    } ctrl_chars_t;

    // One classified item, as handed from the front to the back
    typedef struct packed {
        logic       first;
        logic       esc_data;
        logic [7:0] data;
        logic       last;
        logic       esc_check;
        logic [7:0] check;
    } cmd_t;

    typedef struct packed {
        logic       in_pkt;
        logic [7:0] sum;
    } front_status_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [7:0] START_RESET  = 8'h0F;
    localparam logic [7:0] END_RESET    = 8'h04;
    localparam logic [7:0] ESCAPE_RESET = 8'h05;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

endpackage

`default_nettype wire

[design/dle_stx_etx_packet_framer.sv]
// Top level of the DLE/STX/ETX packet framer: control character registers,
// front end, command queue and back end. Depends on dsef_pkg and all dsef_ modules.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (payload_byte, last_of_packet)
//   out      output     out_valid/out_stall  out_item (line_byte, burst_end)
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// An item becomes 1 to 7 line bytes (2 start chars if first, escape + byte, escape +
// checksum + end if last); the back end emits one line byte per cycle unless stalled.
// The front takes an item every cycle while the 2-entry command queue has room.
// Reset is asynchronous; control chars return to 0x0F/0x04/0x05, no clearing pass.
// out_stall holds the output register; in_stall rises only when the queue is full.
`default_nettype none

module dle_stx_etx_packet_framer
    import dsef_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_item,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    ctrl_chars_t        chars_reg;
    logic               q_push;
    cmd_t               q_cmd;
    logic               q_pop;
    cmd_t               q_head;
    logic               q_full;
    logic               q_empty;
    logic [Q_LVL_W-1:0] q_level;
    front_status_t      front_st;
    back_status_t       back_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg.start_char  <= START_RESET;
            chars_reg.end_char    <= END_RESET;
            chars_reg.escape_char <= ESCAPE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START:  chars_reg.start_char  <= cfg_data;
                CFG_END:    chars_reg.end_char    <= cfg_data;
                CFG_ESCAPE: chars_reg.escape_char <= cfg_data;
                default:    ;
            endcase
        end
    end

    dsef_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .status   (front_st)
    );

    dsef_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty),
        .level    (q_level)
    );

    dsef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_reg),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .status    (back_st)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= Q_LVL_W'(Q_DEPTH))
        else $error("command queue level beyond depth");

    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.busy |-> !q_empty)
        else $error("back end mid-item with an empty queue");

    a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !front_st.in_pkt |-> (front_st.sum == 8'd0))
        else $error("running sum not cleared between packets");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.pop |=> (out_valid && out_item.burst_end))
        else $error("item retired without its final byte in the output register");
`endif

endmodule

`default_nettype wire

[design/dsef_front.sv]
// Front end: accepts payload items, tracks packet state and the running sum,
// and turns each item into a command for the back end. Depends on dsef_pkg.
`default_nettype none

module dsef_front
    import dsef_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ctrl_chars_t   chars,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire in_item_t      in_item,
    input  wire logic          q_full,
    output logic               q_push,
    output cmd_t               q_cmd,
    output front_status_t      status
);

    logic       inside_reg;
    logic       inside_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_new;
    logic       accept;

    function automatic logic is_control(input logic [7:0] value, input ctrl_chars_t c);
        return (value == c.start_char) || (value == c.end_char) || (value == c.escape_char);
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        sum_new         = (inside_reg ? sum_reg : 8'd0) + in_item.payload_byte;
        q_cmd.first     = !inside_reg;
        q_cmd.data      = in_item.payload_byte;
        q_cmd.esc_data  = is_control(in_item.payload_byte, chars);
        q_cmd.last      = in_item.last_of_packet;
        q_cmd.check     = 8'd0 - sum_new;
        q_cmd.esc_check = is_control(q_cmd.check, chars);

        inside_next = inside_reg;
        sum_next    = sum_reg;
        if (accept)
        begin
            inside_next = !in_item.last_of_packet;
            sum_next    = in_item.last_of_packet ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            sum_reg    <= 8'd0;
        end
        else
        begin
            inside_reg <= inside_next;
            sum_reg    <= sum_next;
        end
    end

    assign status.in_pkt = inside_reg;
    assign status.sum    = sum_reg;

endmodule

`default_nettype wire

[design/dsef_fifo.sv]
// Short command queue between the front and back ends of the framer.
// Depends on dsef_pkg (cmd_t, Q_DEPTH and pointer widths).
`default_nettype none

module dsef_fifo
    import dsef_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cmd_t               push_cmd,
    input  wire logic               pop,
    output cmd_t                    head,
    output logic                    full,
    output logic                    empty,
    output logic [Q_LVL_W-1:0]      level
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_LVL_W-1:0] level_reg;
    logic               do_push;
    logic               do_pop;

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_LVL_W-1:0] LVL_FULL = Q_LVL_W'(Q_DEPTH);

    assign full    = (level_reg == LVL_FULL);
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/dsef_back.sv]
// Back end: walks each queued command through its line bytes, one per cycle unless
// the output is stalled, into the output register. Depends on dsef_pkg.
`default_nettype none

module dsef_back
    import dsef_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ctrl_chars_t   chars,
    input  wire cmd_t          head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output out_item_t          out_item,
    output back_status_t       status
);

    typedef enum logic [2:0] {
        PH_S1,
        PH_S2,
        PH_ESCD,
        PH_DATA,
        PH_ESCC,
        PH_CHECK,
        PH_END
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_cur;
    phase_t     phase_next;
    logic       busy_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic [7:0] byte_next;
    logic       final_ph;
    logic       load;

    always_comb
    begin
        if (busy_reg)
        begin
            phase_cur = phase_reg;
        end
        else if (head.first)
        begin
            phase_cur = PH_S1;
        end
        else
        begin
            phase_cur = head.esc_data ? PH_ESCD : PH_DATA;
        end

        final_ph   = 1'b0;
        phase_next = phase_cur;
        case (phase_cur)
            PH_S1:
            begin
                byte_next  = chars.start_char;
                phase_next = PH_S2;
            end
            PH_S2:
            begin
                byte_next  = chars.start_char;
                phase_next = head.esc_data ? PH_ESCD : PH_DATA;
            end
            PH_ESCD:
            begin
                byte_next  = chars.escape_char;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                byte_next = head.data;
                if (head.last)
                begin
                    phase_next = head.esc_check ? PH_ESCC : PH_CHECK;
                end
                else
                begin
                    final_ph = 1'b1;
                end
            end
            PH_ESCC:
            begin
                byte_next  = chars.escape_char;
                phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                byte_next  = head.check;
                phase_next = PH_END;
            end
            PH_END:
            begin
                byte_next = chars.end_char;
                final_ph  = 1'b1;
            end
            default:
            begin
                byte_next = head.data;
                final_ph  = 1'b1;
            end
        endcase
    end

    // output register is free when empty or being taken this cycle
    assign load  = !q_empty && (!out_valid_reg || !out_stall);
    assign q_pop = load && final_ph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_S1;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (load)
        begin
            phase_reg              <= phase_next;
            busy_reg               <= !final_ph;
            out_valid_reg          <= 1'b1;
            out_item_reg.line_byte <= byte_next;
            out_item_reg.burst_end <= final_ph;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;
    assign status.busy = busy_reg;
    assign status.pop  = q_pop;

endmodule

`default_nettype wire
